### rtl/fsc_pkg.sv
//------------------------------------------------------------------------------
// fsc_pkg
// Signature rule table and derived constants for the file signature classifier.
//------------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

    localparam int HeaderLength = 262;
    localparam int NumRules     = 64;
    localparam int NumTerms     = 91;
    localparam int NumRuns      = 102;
    localparam int RunMax       = 28;

    localparam int PosW  = 9;
    localparam int RuleW = 6;
    localparam int TermW = 7;
    localparam int LenW  = 5;

    typedef logic [PosW-1:0]  pos_t;
    typedef logic [RuleW-1:0] rule_t;

    // bytes are right-justified: first byte of a run sits at index len-1
    typedef struct packed {
        logic [TermW-1:0]            term;
        rule_t                       rule;
        pos_t                        off;
        logic [LenW-1:0]             len;
        logic                        nibble;
        logic [RunMax-1:0][7:0]      bytes;
    } run_t;

    typedef run_t  run_arr_t  [NumRuns];
    typedef pos_t  need_arr_t [NumTerms];
    typedef rule_t rmap_arr_t [NumTerms];

    localparam run_arr_t RUNS = '{
        '{7'd0, 6'd0, 9'd0, 5'd3, 1'b0, 224'({8'hFF,8'hD8,8'hFF})},
        '{7'd1, 6'd1, 9'd0, 5'd4, 1'b0, 224'({8'h89,8'h50,8'h4E,8'h47})},
        '{7'd2, 6'd2, 9'd0, 5'd2, 1'b0, 224'({8'h42,8'h4D})},
        '{7'd3, 6'd3, 9'd0, 5'd3, 1'b0, 224'({8'h47,8'h49,8'h46})},
        '{7'd4, 6'd4, 9'd0, 5'd12, 1'b0, 224'({8'hAB,8'h4B,8'h54,8'h58,8'h20,8'h31,
            8'h31,8'hBB,8'h0D,8'h0A,8'h1A,8'h0A})},
        '{7'd5, 6'd5, 9'd0, 5'd4, 1'b0, 224'({8'h13,8'hAB,8'hA1,8'h5C})},
        '{7'd6, 6'd6, 9'd0, 5'd4, 1'b0, 224'({8'h44,8'h44,8'h53,8'h20})},
        '{7'd7, 6'd7, 9'd0, 5'd4, 1'b0, 224'({8'h50,8'h56,8'h52,8'h03})},
        '{7'd8, 6'd8, 9'd0, 5'd10, 1'b0, 224'({8'h23,8'h3F,8'h52,8'h41,8'h44,8'h49,
            8'h41,8'h4E,8'h43,8'h45})},
        '{7'd9, 6'd8, 9'd0, 5'd6, 1'b0, 224'({8'h23,8'h3F,8'h52,8'h47,8'h42,8'h45})},
        '{7'd10, 6'd9, 9'd0, 5'd4, 1'b0, 224'({8'h76,8'h2F,8'h31,8'h01})},
        '{7'd11, 6'd10, 9'd0, 5'd2, 1'b0, 224'({8'h50,8'h35})},
        '{7'd12, 6'd10, 9'd0, 5'd2, 1'b0, 224'({8'h50,8'h36})},
        '{7'd13, 6'd11, 9'd8, 5'd4, 1'b0, 224'({8'h57,8'h45,8'h42,8'h50})},
        '{7'd14, 6'd12, 9'd0, 5'd4, 1'b0, 224'({8'h49,8'h49,8'h2A,8'h00})},
        '{7'd14, 6'd12, 9'd8, 5'd2, 1'b0, 224'({8'h43,8'h52})},
        '{7'd15, 6'd12, 9'd0, 5'd4, 1'b0, 224'({8'h4D,8'h4D,8'h00,8'h2A})},
        '{7'd15, 6'd12, 9'd8, 5'd2, 1'b0, 224'({8'h43,8'h52})},
        '{7'd16, 6'd13, 9'd0, 5'd4, 1'b0, 224'({8'h49,8'h49,8'h2A,8'h00})},
        '{7'd17, 6'd13, 9'd0, 5'd4, 1'b0, 224'({8'h4D,8'h4D,8'h00,8'h2A})},
        '{7'd18, 6'd14, 9'd0, 5'd3, 1'b0, 224'({8'h49,8'h49,8'hBC})},
        '{7'd19, 6'd15, 9'd0, 5'd4, 1'b0, 224'({8'h38,8'h42,8'h50,8'h53})},
        '{7'd20, 6'd16, 9'd0, 5'd4, 1'b0, 224'({8'h50,8'h4B,8'h03,8'h04})},
        '{7'd20, 6'd16, 9'd30, 5'd28, 1'b0, 224'({8'h6D,8'h69,8'h6D,8'h65,8'h74,8'h79,
            8'h70,8'h65,8'h61,8'h70,8'h70,8'h6C,8'h69,8'h63,8'h61,8'h74,8'h69,8'h6F,
            8'h6E,8'h2F,8'h65,8'h70,8'h75,8'h62,8'h2B,8'h7A,8'h69,8'h70})},
        '{7'd21, 6'd17, 9'd0, 5'd4, 1'b0, 224'({8'h50,8'h4B,8'h03,8'h04})},
        '{7'd21, 6'd17, 9'd30, 5'd20, 1'b0, 224'({8'h4D,8'h45,8'h54,8'h41,8'h2D,8'h49,
            8'h4E,8'h46,8'h2F,8'h6D,8'h6F,8'h7A,8'h69,8'h6C,8'h6C,8'h61,8'h2E,8'h72,
            8'h73,8'h61})},
        '{7'd22, 6'd18, 9'd0, 5'd4, 1'b0, 224'({8'h50,8'h4B,8'h03,8'h04})},
        '{7'd23, 6'd18, 9'd0, 5'd4, 1'b0, 224'({8'h50,8'h4B,8'h03,8'h06})},
        '{7'd24, 6'd18, 9'd0, 5'd4, 1'b0, 224'({8'h50,8'h4B,8'h03,8'h08})},
        '{7'd25, 6'd18, 9'd0, 5'd4, 1'b0, 224'({8'h50,8'h4B,8'h05,8'h04})},
        '{7'd26, 6'd18, 9'd0, 5'd4, 1'b0, 224'({8'h50,8'h4B,8'h05,8'h06})},
        '{7'd27, 6'd18, 9'd0, 5'd4, 1'b0, 224'({8'h50,8'h4B,8'h05,8'h08})},
        '{7'd28, 6'd18, 9'd0, 5'd4, 1'b0, 224'({8'h50,8'h4B,8'h07,8'h04})},
        '{7'd29, 6'd18, 9'd0, 5'd4, 1'b0, 224'({8'h50,8'h4B,8'h07,8'h06})},
        '{7'd30, 6'd18, 9'd0, 5'd4, 1'b0, 224'({8'h50,8'h4B,8'h07,8'h08})},
        '{7'd31, 6'd19, 9'd257, 5'd5, 1'b0, 224'({8'h75,8'h73,8'h74,8'h61,8'h72})},
        '{7'd32, 6'd20, 9'd0, 5'd7, 1'b0, 224'({8'h52,8'h61,8'h72,8'h21,8'h1A,8'h07,
            8'h00})},
        '{7'd33, 6'd20, 9'd0, 5'd7, 1'b0, 224'({8'h52,8'h61,8'h72,8'h21,8'h1A,8'h07,
            8'h01})},
        '{7'd34, 6'd21, 9'd0, 5'd3, 1'b0, 224'({8'h1F,8'h8B,8'h08})},
        '{7'd35, 6'd22, 9'd0, 5'd3, 1'b0, 224'({8'h42,8'h5A,8'h68})},
        '{7'd36, 6'd23, 9'd0, 5'd6, 1'b0, 224'({8'h37,8'h7A,8'hBC,8'hAF,8'h27,8'h1C})},
        '{7'd37, 6'd24, 9'd0, 5'd2, 1'b0, 224'({8'h78,8'h01})},
        '{7'd38, 6'd25, 9'd0, 5'd8, 1'b0, 224'({8'h00,8'h00,8'h00,8'h18,8'h66,8'h74,
            8'h79,8'h70})},
        '{7'd39, 6'd25, 9'd0, 5'd8, 1'b0, 224'({8'h00,8'h00,8'h00,8'h20,8'h66,8'h74,
            8'h79,8'h70})},
        '{7'd40, 6'd25, 9'd0, 5'd4, 1'b0, 224'({8'h33,8'h67,8'h70,8'h35})},
        '{7'd41, 6'd25, 9'd0, 5'd12, 1'b0, 224'({8'h00,8'h00,8'h00,8'h1C,8'h66,8'h74,
            8'h79,8'h70,8'h6D,8'h70,8'h34,8'h32})},
        '{7'd41, 6'd25, 9'd16, 5'd12, 1'b0, 224'({8'h6D,8'h70,8'h34,8'h31,8'h6D,8'h70,
            8'h34,8'h32,8'h69,8'h73,8'h6F,8'h6D})},
        '{7'd42, 6'd25, 9'd0, 5'd12, 1'b0, 224'({8'h00,8'h00,8'h00,8'h1C,8'h66,8'h74,
            8'h79,8'h70,8'h69,8'h73,8'h6F,8'h6D})},
        '{7'd43, 6'd25, 9'd0, 5'd16, 1'b0, 224'({8'h00,8'h00,8'h00,8'h1C,8'h66,8'h74,
            8'h79,8'h70,8'h6D,8'h70,8'h34,8'h32,8'h00,8'h00,8'h00,8'h00})},
        '{7'd44, 6'd26, 9'd0, 5'd11, 1'b0, 224'({8'h00,8'h00,8'h00,8'h1C,8'h66,8'h74,
            8'h79,8'h70,8'h4D,8'h34,8'h56})},
        '{7'd45, 6'd27, 9'd0, 5'd4, 1'b0, 224'({8'h4D,8'h54,8'h68,8'h64})},
        '{7'd46, 6'd28, 9'd31, 5'd8, 1'b0, 224'({8'h6D,8'h61,8'h74,8'h72,8'h6F,8'h73,
            8'h6B,8'h61})},
        '{7'd47, 6'd29, 9'd0, 5'd4, 1'b0, 224'({8'h1A,8'h45,8'hDF,8'hA3})},
        '{7'd48, 6'd30, 9'd0, 5'd8, 1'b0, 224'({8'h00,8'h00,8'h00,8'h14,8'h66,8'h74,
            8'h79,8'h70})},
        '{7'd49, 6'd31, 9'd0, 5'd4, 1'b0, 224'({8'h52,8'h49,8'h46,8'h46})},
        '{7'd49, 6'd31, 9'd8, 5'd3, 1'b0, 224'({8'h41,8'h56,8'h49})},
        '{7'd50, 6'd32, 9'd0, 5'd10, 1'b0, 224'({8'h30,8'h26,8'hB2,8'h75,8'h8E,8'h66,
            8'hCF,8'h11,8'hA6,8'hD9})},
        '{7'd51, 6'd33, 9'd0, 5'd3, 1'b0, 224'({8'h00,8'h00,8'h01})},
        '{7'd51, 6'd33, 9'd3, 5'd1, 1'b1, 224'({8'hB0})},
        '{7'd52, 6'd34, 9'd0, 5'd3, 1'b0, 224'({8'h49,8'h44,8'h33})},
        '{7'd53, 6'd34, 9'd0, 5'd2, 1'b0, 224'({8'hFF,8'hFB})},
        '{7'd54, 6'd35, 9'd4, 5'd7, 1'b0, 224'({8'h66,8'h74,8'h79,8'h70,8'h4D,8'h34,
            8'h41})},
        '{7'd55, 6'd35, 9'd0, 5'd4, 1'b0, 224'({8'h4D,8'h34,8'h41,8'h20})},
        '{7'd56, 6'd36, 9'd28, 5'd8, 1'b0, 224'({8'h4F,8'h70,8'h75,8'h73,8'h48,8'h65,
            8'h61,8'h64})},
        '{7'd57, 6'd37, 9'd0, 5'd4, 1'b0, 224'({8'h4F,8'h67,8'h67,8'h53})},
        '{7'd58, 6'd38, 9'd0, 5'd4, 1'b0, 224'({8'h66,8'h4C,8'h61,8'h43})},
        '{7'd59, 6'd39, 9'd0, 5'd4, 1'b0, 224'({8'h52,8'h49,8'h46,8'h46})},
        '{7'd59, 6'd39, 9'd8, 5'd4, 1'b0, 224'({8'h57,8'h41,8'h56,8'h45})},
        '{7'd60, 6'd40, 9'd0, 5'd6, 1'b0, 224'({8'h23,8'h21,8'h41,8'h4D,8'h52,8'h0A})},
        '{7'd61, 6'd41, 9'd0, 5'd4, 1'b0, 224'({8'h25,8'h50,8'h44,8'h46})},
        '{7'd62, 6'd42, 9'd0, 5'd2, 1'b0, 224'({8'h4D,8'h5A})},
        '{7'd63, 6'd43, 9'd0, 5'd3, 1'b0, 224'({8'h43,8'h57,8'h53})},
        '{7'd64, 6'd43, 9'd0, 5'd3, 1'b0, 224'({8'h46,8'h57,8'h53})},
        '{7'd65, 6'd44, 9'd0, 5'd5, 1'b0, 224'({8'h7B,8'h5C,8'h72,8'h74,8'h66})},
        '{7'd66, 6'd45, 9'd0, 5'd8, 1'b0, 224'({8'h77,8'h4F,8'h46,8'h46,8'h00,8'h01,
            8'h00,8'h00})},
        '{7'd67, 6'd45, 9'd0, 5'd8, 1'b0, 224'({8'h77,8'h4F,8'h46,8'h46,8'h4F,8'h54,
            8'h54,8'h4F})},
        '{7'd68, 6'd46, 9'd0, 5'd8, 1'b0, 224'({8'h77,8'h4F,8'h46,8'h32,8'h00,8'h01,
            8'h00,8'h00})},
        '{7'd69, 6'd46, 9'd0, 5'd8, 1'b0, 224'({8'h77,8'h4F,8'h46,8'h32,8'h4F,8'h54,
            8'h54,8'h4F})},
        '{7'd70, 6'd47, 9'd8, 5'd3, 1'b0, 224'({8'h00,8'h00,8'h01})},
        '{7'd70, 6'd47, 9'd34, 5'd2, 1'b0, 224'({8'h4C,8'h50})},
        '{7'd71, 6'd47, 9'd8, 5'd3, 1'b0, 224'({8'h01,8'h00,8'h02})},
        '{7'd71, 6'd47, 9'd34, 5'd2, 1'b0, 224'({8'h4C,8'h50})},
        '{7'd72, 6'd47, 9'd8, 5'd3, 1'b0, 224'({8'h02,8'h00,8'h02})},
        '{7'd72, 6'd47, 9'd34, 5'd2, 1'b0, 224'({8'h4C,8'h50})},
        '{7'd73, 6'd48, 9'd0, 5'd5, 1'b0, 224'({8'h00,8'h01,8'h00,8'h00,8'h00})},
        '{7'd74, 6'd49, 9'd0, 5'd5, 1'b0, 224'({8'h4F,8'h54,8'h54,8'h4F,8'h00})},
        '{7'd75, 6'd50, 9'd0, 5'd4, 1'b0, 224'({8'h00,8'h00,8'h01,8'h00})},
        '{7'd76, 6'd51, 9'd0, 5'd4, 1'b0, 224'({8'h46,8'h4C,8'h56,8'h01})},
        '{7'd77, 6'd52, 9'd0, 5'd2, 1'b0, 224'({8'h25,8'h21})},
        '{7'd78, 6'd53, 9'd0, 5'd6, 1'b0, 224'({8'hFD,8'h37,8'h7A,8'h58,8'h5A,8'h00})},
        '{7'd79, 6'd54, 9'd0, 5'd4, 1'b0, 224'({8'h53,8'h51,8'h4C,8'h69})},
        '{7'd80, 6'd55, 9'd0, 5'd4, 1'b0, 224'({8'h4E,8'h45,8'h53,8'h1A})},
        '{7'd81, 6'd56, 9'd0, 5'd4, 1'b0, 224'({8'h43,8'h72,8'h32,8'h34})},
        '{7'd82, 6'd57, 9'd0, 5'd4, 1'b0, 224'({8'h4D,8'h53,8'h43,8'h46})},
        '{7'd83, 6'd57, 9'd0, 5'd4, 1'b0, 224'({8'h49,8'h53,8'h63,8'h28})},
        '{7'd84, 6'd58, 9'd0, 5'd21, 1'b0, 224'({8'h21,8'h3C,8'h61,8'h72,8'h63,8'h68,
            8'h3E,8'h0A,8'h64,8'h65,8'h62,8'h69,8'h61,8'h6E,8'h2D,8'h62,8'h69,8'h6E,
            8'h61,8'h72,8'h79})},
        '{7'd85, 6'd59, 9'd0, 5'd7, 1'b0, 224'({8'h21,8'h3C,8'h61,8'h72,8'h63,8'h68,
            8'h3E})},
        '{7'd86, 6'd60, 9'd0, 5'd4, 1'b0, 224'({8'hED,8'hAB,8'hEE,8'hDB})},
        '{7'd87, 6'd61, 9'd0, 5'd2, 1'b0, 224'({8'h1F,8'hA0})},
        '{7'd88, 6'd61, 9'd0, 5'd2, 1'b0, 224'({8'h1F,8'h9D})},
        '{7'd89, 6'd62, 9'd0, 5'd4, 1'b0, 224'({8'h4C,8'h5A,8'h49,8'h50})},
        '{7'd90, 6'd63, 9'd0, 5'd8, 1'b0, 224'({8'hD0,8'hCF,8'h11,8'hE0,8'hA1,8'hB1,
            8'h1A,8'hE1})}
    };

    // bytes needed before an alternative can count as complete
    function automatic need_arr_t term_need_f();
        need_arr_t n;
        pos_t      e;
        for (int t = 0; t < NumTerms; t++) begin
            n[t] = '0;
        end
        for (int r = 0; r < NumRuns; r++) begin
            e = RUNS[r].off + PosW'(RUNS[r].len);
            if (e > n[RUNS[r].term]) begin
                n[RUNS[r].term] = e;
            end
        end
        return n;
    endfunction

    function automatic rmap_arr_t term_rule_f();
        rmap_arr_t m;
        for (int t = 0; t < NumTerms; t++) begin
            m[t] = '0;
        end
        for (int r = 0; r < NumRuns; r++) begin
            m[RUNS[r].term] = RUNS[r].rule;
        end
        return m;
    endfunction

    localparam need_arr_t TERM_NEED = term_need_f();
    localparam rmap_arr_t TERM_RULE = term_rule_f();

endpackage

`default_nettype wire

### rtl/file_signature_classifier_unit.sv
//------------------------------------------------------------------------------
// file_signature_classifier_unit
// Matches leading file bytes against signature rules, reports first hit.
//------------------------------------------------------------------------------
// the result appears on m_* in the cycle after the word marked tlast is accepted
// throughput: one word per cycle while no result waits on a stalled m_*; the compare of each byte against every rule
// and the match-state update finish in the same cycle the word is accepted
// reset: aresetn low clears the output valid flag and byte position and sets all match flags
//------------------------------------------------------------------------------
`default_nettype none

module file_signature_classifier_unit
    import fsc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [5:0] type_code, [7:6] zero
    output logic            m_tuser    // found
);

    pos_t                pos_reg, pos_next;
    logic [NumTerms-1:0] alive_reg, alive_next, alive_upd;
    logic [NumTerms-1:0] kill;
    logic                m_valid_reg, m_valid_next;
    logic                found_reg, found_next;
    rule_t               code_reg, code_next;
    logic [NumRules-1:0] hit;
    logic                accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // compare the byte against every run covering this position
    always_comb begin
        kill = '0;
        for (int r = 0; r < NumRuns; r++) begin
            for (int k = 0; k < RunMax; k++) begin
                if (k < int'(RUNS[r].len) && pos_reg == RUNS[r].off + PosW'(k)) begin
                    if (RUNS[r].nibble) begin
                        if (s_tdata[7:4] != RUNS[r].bytes[int'(RUNS[r].len) - 1 - k][7:4])
                            kill[RUNS[r].term] = 1'b1;
                    end else begin
                        if (s_tdata != RUNS[r].bytes[int'(RUNS[r].len) - 1 - k])
                            kill[RUNS[r].term] = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        if (pos_reg < PosW'(HeaderLength)) begin
            pos_next  = pos_reg + 1'b1;
            alive_upd = alive_reg & ~kill;
        end else begin
            pos_next  = pos_reg;
            alive_upd = alive_reg;
        end
    end

    // rules with a complete, still alive alternative, then lowest index wins
    always_comb begin
        hit = '0;
        for (int t = 0; t < NumTerms; t++) begin
            if (alive_upd[t] && TERM_NEED[t] <= pos_next)
                hit[TERM_RULE[t]] = 1'b1;
        end
        found_next = 1'b0;
        code_next  = '0;
        for (int r = NumRules - 1; r >= 0; r--) begin
            if (hit[r]) begin
                found_next = 1'b1;
                code_next  = RuleW'(r);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        alive_next   = alive_reg;
        if (accept) begin
            alive_next = alive_upd;
            if (s_tlast) begin
                m_valid_next = 1'b1;
                alive_next   = '1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            alive_reg   <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            alive_reg   <= alive_next;
            if (accept) begin
                pos_reg <= s_tlast ? pos_t'(0) : pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            found_reg <= found_next;
            code_reg  <= code_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = {2'b00, code_reg};

endmodule

`default_nettype wire
